FILE: hw/rtl/i2c_master_byte_engine_unit_macros.svh
// Assertion macros for the I2C master byte engine.
// Needs clk and rst in the scope of use.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define I2CME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/i2cme_pkg.sv
// Shared types and codes for the I2C master byte engine.
// No dependencies.
`default_nettype none

package i2cme_pkg;

  localparam int PHASE_COUNT_BITS_DEF = 16;
  localparam int Q_DEPTH              = 4;

  localparam logic [2:0] OP_IDLE   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_FIN    = 3'd5;
  localparam logic [2:0] OP_FIN_WR = 3'd6;

  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd48;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd255;
  localparam logic [7:0]  MSB_MASK        = 8'h80;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       final_req;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cme_front.sv
// Front end: accepts tick items and decodes the command field.
// Depends on i2cme_pkg.
`default_nettype none

module i2cme_front
  import i2cme_pkg::*;
(
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // command[2:0], tx_byte, final_req, sda_in
  input  wire logic        q_full,
  output logic             push,
  output item_t            item
);

  logic [2:0] cmd;

  assign cmd      = s_tdata[2:0];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    unique case (cmd)
      OP_START, OP_STOP, OP_WRITE, OP_READ: item.op = cmd;
      default:                              item.op = OP_IDLE;
    endcase
    item.tx_byte   = s_tdata[10:3];
    item.final_req = s_tdata[11];
    item.sda_in    = s_tdata[12];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cme_fifo.sv
// Short queue between front and back.
// Depends on i2cme_pkg.
`default_nettype none

module i2cme_fifo
  import i2cme_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output item_t      rd_item
);

  localparam int PW = $clog2(Q_DEPTH);

  item_t         mem [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(Q_DEPTH));
  assign valid   = (count != '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cme_back.sv
// Back end: bus phase sequencer, configuration registers and result register.
// Depends on i2cme_pkg.
`default_nettype none

module i2cme_back
  import i2cme_pkg::*;
#(
  parameter int PHASE_COUNT_BITS = PHASE_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             res
);

  localparam int PCB = PHASE_COUNT_BITS;
  localparam int HW  = (PCB > 16) ? PCB : 16;

  logic [15:0]    phase_ticks;
  logic [7:0]     poll_limit;

  logic [2:0]     operation,   operation_next;
  logic [2:0]     phase_index, phase_index_next;
  logic [3:0]     bit_index,   bit_index_next;
  logic [PCB-1:0] tick_count,  tick_count_next;
  logic [7:0]     poll_count,  poll_count_next;
  logic [7:0]     shift_byte,  shift_byte_next;
  logic           scl,         scl_next;
  logic           sda,         sda_next;
  logic           drv,         drv_next;
  logic           ack_missing, ack_missing_next;
  logic           read_final,  read_final_next;
  logic [7:0]     rx_last,     rx_last_next;
  logic           done;

  logic [15:0]    h16;
  logic [HW-1:0]  h_wide;
  logic [HW-1:0]  mask_wide;
  logic [PCB-1:0] hold_val;
  logic [7:0]     lim;

  assign pop = q_valid && (!out_valid || out_ready);

  assign h16       = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
  assign h_wide    = HW'(h16);
  assign mask_wide = {HW{1'b1}} >> (HW - PCB);
  assign hold_val  = (h_wide > mask_wide) ? {PCB{1'b1}} : h_wide[PCB-1:0];
  assign lim       = (poll_limit == 8'd0) ? 8'd1 : poll_limit;

  always_comb begin
    operation_next   = operation;
    phase_index_next = phase_index;
    bit_index_next   = bit_index;
    tick_count_next  = tick_count;
    poll_count_next  = poll_count;
    shift_byte_next  = shift_byte;
    scl_next         = scl;
    sda_next         = sda;
    drv_next         = drv;
    ack_missing_next = ack_missing;
    read_final_next  = read_final;
    rx_last_next     = rx_last;
    done             = 1'b0;

    if (operation == OP_IDLE && q_item.op != OP_IDLE) begin
      operation_next   = q_item.op;
      phase_index_next = 3'd0;
      bit_index_next   = 4'd0;
      tick_count_next  = '0;
      poll_count_next  = 8'd0;
      if (q_item.op == OP_WRITE) begin
        shift_byte_next  = q_item.tx_byte;
        ack_missing_next = 1'b1;
      end else if (q_item.op == OP_READ) begin
        shift_byte_next = 8'd0;
        read_final_next = q_item.final_req;
      end
    end

    if (operation_next != OP_IDLE) begin
      if (tick_count_next != '0) begin
        tick_count_next = tick_count_next - PCB'(1);
      end else begin
        unique case (operation_next)
          OP_START: begin
            unique case (phase_index_next)
              3'd0: begin sda_next = 1'b1; drv_next = 1'b1; end
              3'd1: scl_next = 1'b1;
              3'd2: sda_next = 1'b0;
              default: scl_next = 1'b0;
            endcase
            tick_count_next = hold_val;
            if (phase_index_next >= 3'd3) operation_next = OP_FIN;
            else phase_index_next = phase_index_next + 3'd1;
          end
          OP_STOP: begin
            unique case (phase_index_next)
              3'd0: begin sda_next = 1'b0; drv_next = 1'b1; end
              3'd1: scl_next = 1'b0;
              3'd2: scl_next = 1'b1;
              default: sda_next = 1'b1;
            endcase
            tick_count_next = hold_val;
            if (phase_index_next >= 3'd3) operation_next = OP_FIN;
            else phase_index_next = phase_index_next + 3'd1;
          end
          OP_WRITE: begin
            unique case (phase_index_next)
              3'd0: begin
                scl_next = 1'b0; tick_count_next = hold_val; phase_index_next = 3'd1;
              end
              3'd1: begin
                sda_next = |(shift_byte_next & MSB_MASK);
                drv_next = 1'b1;
                shift_byte_next = {shift_byte_next[6:0], 1'b0};
                tick_count_next = hold_val;
                phase_index_next = 3'd2;
              end
              3'd2: begin
                scl_next = 1'b1; tick_count_next = hold_val; phase_index_next = 3'd3;
              end
              3'd3: begin
                scl_next = 1'b0;
                tick_count_next = hold_val;
                bit_index_next = bit_index_next + 4'd1;
                phase_index_next = (bit_index_next < 4'd8) ? 3'd1 : 3'd4;
              end
              3'd4: begin
                drv_next = 1'b0; sda_next = 1'b1;
                tick_count_next = hold_val; phase_index_next = 3'd5;
              end
              3'd5: begin
                scl_next = 1'b1; tick_count_next = hold_val;
                poll_count_next = 8'd0; phase_index_next = 3'd6;
              end
              3'd6: begin
                tick_count_next = '0;
                if (!q_item.sda_in) begin
                  ack_missing_next = 1'b0;
                  phase_index_next = 3'd7;
                end else begin
                  poll_count_next = poll_count_next + 8'd1;
                  if (poll_count_next >= lim) phase_index_next = 3'd7;
                end
              end
              default: begin
                scl_next = 1'b0; tick_count_next = hold_val; operation_next = OP_FIN_WR;
              end
            endcase
          end
          OP_READ: begin
            unique case (phase_index_next)
              3'd0: begin
                scl_next = 1'b0; drv_next = 1'b0;
                tick_count_next = hold_val; phase_index_next = 3'd1;
              end
              3'd1: begin
                scl_next = 1'b1; tick_count_next = hold_val; phase_index_next = 3'd2;
              end
              3'd2: begin
                tick_count_next = hold_val; phase_index_next = 3'd3;
              end
              3'd3: begin
                shift_byte_next = {shift_byte_next[6:0], q_item.sda_in};
                scl_next = 1'b0;
                tick_count_next = hold_val;
                bit_index_next = bit_index_next + 4'd1;
                phase_index_next = (bit_index_next < 4'd8) ? 3'd0 : 3'd4;
              end
              3'd4: begin
                drv_next = 1'b1; scl_next = 1'b0;
                tick_count_next = hold_val; phase_index_next = 3'd5;
              end
              3'd5: begin
                sda_next = read_final_next;
                tick_count_next = hold_val; phase_index_next = 3'd6;
              end
              3'd6: begin
                scl_next = 1'b1; tick_count_next = hold_val; phase_index_next = 3'd7;
              end
              default: begin
                scl_next = 1'b0; rx_last_next = shift_byte_next;
                tick_count_next = hold_val; operation_next = OP_FIN;
              end
            endcase
          end
          OP_FIN_WR: begin
            sda_next = 1'b1; drv_next = 1'b1;
            operation_next = OP_IDLE;
            done = 1'b1;
          end
          default: begin
            operation_next = OP_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
      poll_limit  <= POLL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_TICKS: phase_ticks <= cfg_data;
        REG_POLL_LIMIT:  poll_limit  <= cfg_data[7:0];
        default:         phase_ticks <= phase_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= OP_IDLE;
      phase_index <= 3'd0;
      bit_index   <= 4'd0;
      tick_count  <= '0;
      poll_count  <= 8'd0;
      shift_byte  <= 8'd0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drv         <= 1'b1;
      ack_missing <= 1'b0;
      read_final  <= 1'b0;
      rx_last     <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        operation   <= operation_next;
        phase_index <= phase_index_next;
        bit_index   <= bit_index_next;
        tick_count  <= tick_count_next;
        poll_count  <= poll_count_next;
        shift_byte  <= shift_byte_next;
        scl         <= scl_next;
        sda         <= sda_next;
        drv         <= drv_next;
        ack_missing <= ack_missing_next;
        read_final  <= read_final_next;
        rx_last     <= rx_last_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.scl_level <= scl_next;
      res.sda_level <= sda_next;
      res.sda_drive <= drv_next;
      res.busy_res  <= (operation_next != OP_IDLE);
      res.done_res  <= done;
      res.rx_byte   <= rx_last_next;
      res.nack      <= ack_missing_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_engine_unit.sv
// I2C master byte engine, top level. A tick item is written into the queue, then the
// sequencer step writes its result into the result register.
// Throughput: one tick item per cycle, set by the sequencer step, unless a held result waits on m_tready.
// Reset (synchronous, rst high): sequencer idle, SCL high, SDA driven high,
// phase_ticks 48, ack_poll_limit 255, queue and result register empty.
`default_nettype none

`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_master_byte_engine_unit
  import i2cme_pkg::*;
#(
  parameter int PHASE_COUNT_BITS = PHASE_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // command[2:0], tx_byte[10:3], final_req[11], sda_in[12]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0] m_tdata,  // scl_level, sda_level, sda_drive, busy_res, done_res,
                                // rx_byte[12:5], nack[13]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  item_t fe_item;
  item_t q_item;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  res_t  res;

  i2cme_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .item     (fe_item)
  );

  i2cme_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (fe_item),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .rd_item (q_item)
  );

  i2cme_back #(
    .PHASE_COUNT_BITS (PHASE_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {2'b00, res.nack, res.rx_byte, res.done_res, res.busy_res,
                    res.sda_drive, res.sda_level, res.scl_level};

  `I2CME_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[4], !m_tdata[3], "done while busy")
  `I2CME_ASSERT_NOW(a_ready_empty, !q_valid, s_tready, "not ready with empty queue")
  `I2CME_ASSERT_NOW(a_pop_valid, pop, q_valid, "pop from empty queue")
  `I2CME_ASSERT_NEXT(a_push_fill, push && !pop, q_valid, "pushed item lost")

endmodule

`default_nettype wire

FILE: dv/i2c_master_byte_engine_unit_tb.sv
// Self-checking testbench for the I2C master byte engine: drives bus ticks on the input
// stream and compares every output transfer with a per-tick model of the sequencer.
// Depends on i2cme_pkg and the i2c_master_byte_engine_unit RTL.
module i2c_master_byte_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cme_pkg::*;

  localparam logic [2:0] CMD_NONE  = OP_IDLE;
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_TICKS    = 150;

  localparam res_t AT_REST = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
                               busy_res: 1'b0, done_res: 1'b0, rx_byte: 8'h00, nack: 1'b0};
  localparam res_t START_ENTRY = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
                                   busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00, nack: 1'b0};

  typedef enum logic [1:0] {SDA_RAND, SDA_HIGH, SDA_LOW, SDA_MOSTLY_HIGH} sda_plan_e;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    logic [2:0]  cmd;
    logic [7:0]  tx;
    logic        fin;
    logic        sda;
    logic        go_on;    // keep ticking until the command completes
    sda_plan_e   plan;
    logic        typed;
    res_t        exp;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // command[2:0], tx_byte[10:3], final_req[11], sda_in[12]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // scl_level, sda_level, sda_drive, busy_res, done_res,
                              // rx_byte[12:5], nack[13]
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_PHASE_TICKS;
  logic [15:0] cfg_data = '0;

  i2c_master_byte_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine model state
  logic [15:0] ticks_cfg = PHASE_TICKS_RST;
  logic [7:0]  poll_cfg  = POLL_LIMIT_RST;
  logic [2:0]  eng_op    = OP_IDLE;
  logic [2:0]  eng_phase = '0;
  logic [3:0]  eng_bit   = '0;
  logic [15:0] eng_wait  = '0;
  logic [7:0]  eng_polls = '0;
  logic [7:0]  eng_shift = '0;
  logic [7:0]  eng_rx    = '0;
  logic        eng_scl   = 1'b1;
  logic        eng_sda   = 1'b1;
  logic        eng_drv   = 1'b1;
  logic        eng_nack  = 1'b0;
  logic        eng_final = 1'b0;

  res_t due_outputs[$];
  int   errors = 0;
  int   cycles = 0;
  int   src_idle_pct = 16;
  int   sink_idle_pct = 69;
  bit   hold_off_req = 1'b0;

  function automatic logic [15:0] phase_hold();
    return (ticks_cfg == 16'd0) ? 16'd0 : ticks_cfg - 16'd1;
  endfunction

  function automatic res_t engine_tick(input logic [2:0] cmd, input logic [7:0] tx,
                                       input logic fin, input logic sda);
    logic       finished;
    logic [7:0] lim;
    res_t       r;
    finished = 1'b0;
    lim = (poll_cfg == 8'd0) ? 8'd1 : poll_cfg;
    if (eng_op == OP_IDLE && cmd >= OP_START && cmd <= OP_READ) begin
      eng_op = cmd;
      eng_phase = '0;
      eng_bit = '0;
      eng_wait = '0;
      eng_polls = '0;
      if (cmd == OP_WRITE) begin
        eng_shift = tx;
        eng_nack = 1'b1;
      end else if (cmd == OP_READ) begin
        eng_shift = '0;
        eng_final = fin;
      end
    end
    if (eng_op != OP_IDLE) begin
      if (eng_wait != 16'd0) begin
        eng_wait = eng_wait - 16'd1;
      end else begin
        case (eng_op)
          OP_START: begin
            case (eng_phase)
              3'd0: begin
                eng_sda = 1'b1;
                eng_drv = 1'b1;
              end
              3'd1: eng_scl = 1'b1;
              3'd2: eng_sda = 1'b0;
              default: eng_scl = 1'b0;
            endcase
            eng_wait = phase_hold();
            if (eng_phase >= 3'd3) eng_op = OP_FIN;
            else eng_phase = eng_phase + 3'd1;
          end
          OP_STOP: begin
            case (eng_phase)
              3'd0: begin
                eng_sda = 1'b0;
                eng_drv = 1'b1;
              end
              3'd1: eng_scl = 1'b0;
              3'd2: eng_scl = 1'b1;
              default: eng_sda = 1'b1;
            endcase
            eng_wait = phase_hold();
            if (eng_phase >= 3'd3) eng_op = OP_FIN;
            else eng_phase = eng_phase + 3'd1;
          end
          OP_WRITE: begin
            case (eng_phase)
              3'd0: begin
                eng_scl = 1'b0;
                eng_wait = phase_hold();
                eng_phase = 3'd1;
              end
              3'd1: begin
                eng_sda = eng_shift[7];
                eng_drv = 1'b1;
                eng_shift = {eng_shift[6:0], 1'b0};
                eng_wait = phase_hold();
                eng_phase = 3'd2;
              end
              3'd2: begin
                eng_scl = 1'b1;
                eng_wait = phase_hold();
                eng_phase = 3'd3;
              end
              3'd3: begin
                eng_scl = 1'b0;
                eng_wait = phase_hold();
                eng_bit = eng_bit + 4'd1;
                eng_phase = (eng_bit < 4'd8) ? 3'd1 : 3'd4;
              end
              3'd4: begin
                eng_drv = 1'b0;
                eng_sda = 1'b1;
                eng_wait = phase_hold();
                eng_phase = 3'd5;
              end
              3'd5: begin
                eng_scl = 1'b1;
                eng_wait = phase_hold();
                eng_polls = '0;
                eng_phase = 3'd6;
              end
              3'd6: begin
                eng_wait = '0;
                if (!sda) begin
                  eng_nack = 1'b0;
                  eng_phase = 3'd7;
                end else begin
                  eng_polls = eng_polls + 8'd1;
                  if (eng_polls >= lim) eng_phase = 3'd7;
                end
              end
              default: begin
                eng_scl = 1'b0;
                eng_wait = phase_hold();
                eng_op = OP_FIN_WR;
              end
            endcase
          end
          OP_READ: begin
            case (eng_phase)
              3'd0: begin
                eng_scl = 1'b0;
                eng_drv = 1'b0;
                eng_wait = phase_hold();
                eng_phase = 3'd1;
              end
              3'd1: begin
                eng_scl = 1'b1;
                eng_wait = phase_hold();
                eng_phase = 3'd2;
              end
              3'd2: begin
                eng_wait = phase_hold();
                eng_phase = 3'd3;
              end
              3'd3: begin
                eng_shift = {eng_shift[6:0], sda};
                eng_scl = 1'b0;
                eng_wait = phase_hold();
                eng_bit = eng_bit + 4'd1;
                eng_phase = (eng_bit < 4'd8) ? 3'd0 : 3'd4;
              end
              3'd4: begin
                eng_drv = 1'b1;
                eng_scl = 1'b0;
                eng_wait = phase_hold();
                eng_phase = 3'd5;
              end
              3'd5: begin
                eng_sda = eng_final;
                eng_wait = phase_hold();
                eng_phase = 3'd6;
              end
              3'd6: begin
                eng_scl = 1'b1;
                eng_wait = phase_hold();
                eng_phase = 3'd7;
              end
              default: begin
                eng_scl = 1'b0;
                eng_rx = eng_shift;
                eng_wait = phase_hold();
                eng_op = OP_FIN;
              end
            endcase
          end
          OP_FIN_WR: begin
            eng_sda = 1'b1;
            eng_drv = 1'b1;
            eng_op = OP_IDLE;
            finished = 1'b1;
          end
          default: begin
            eng_op = OP_IDLE;
            finished = 1'b1;
          end
        endcase
      end
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.sda_drive = eng_drv;
    r.busy_res  = (eng_op != OP_IDLE);
    r.done_res  = finished;
    r.rx_byte   = eng_rx;
    r.nack      = eng_nack;
    return r;
  endfunction

  function automatic logic sda_for(input sda_plan_e plan);
    case (plan)
      SDA_HIGH:        return 1'b1;
      SDA_LOW:         return 1'b0;
      SDA_MOSTLY_HIGH: return ($urandom_range(99) < 85);
      default:         return 1'($urandom_range(1));
    endcase
  endfunction

  function automatic step_row_t tick_row(input logic [2:0] cmd, input logic [7:0] tx,
                                         input logic fin, input logic sda, input logic go_on,
                                         input sda_plan_e plan, input logic typed,
                                         input res_t exp);
    step_row_t r;
    r = '0;
    r.cmd = cmd;
    r.tx = tx;
    r.fin = fin;
    r.sda = sda;
    r.go_on = go_on;
    r.plan = plan;
    r.typed = typed;
    r.exp = exp;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic idx, input logic [15:0] val);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic fin,
                           input logic sda);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, sda, fin, tx, cmd};
    do @(posedge clk); while (!s_tready);
    due_outputs.push_back(engine_tick(cmd, tx, fin, sda));
  endtask

  // tick on until the engine is idle; noise_pct of the ticks carry a random command code
  task automatic run_out(input sda_plan_e plan, input int noise_pct, output int n);
    logic [2:0] cmd;
    n = 0;
    while (eng_op != OP_IDLE) begin
      cmd = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
      send_tick(cmd, 8'($urandom), 1'($urandom_range(1)), sda_for(plan));
      n++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PHASE_TICKS) ticks_cfg = val;
    else poll_cfg = val[7:0];
  endtask

  task automatic retune();
    int r;
    logic [15:0] pt;
    logic [7:0] pl;
    r = $urandom_range(99);
    pt = (r < 70) ? 16'($urandom_range(1, 3)) : (r < 85) ? 16'd0 : 16'($urandom_range(4, 8));
    r = $urandom_range(99);
    pl = (r < 40) ? 8'($urandom_range(1, 4)) : (r < 60) ? 8'd0 :
         (r < 80) ? 8'd255 : 8'($urandom_range(255));
    write_reg(REG_PHASE_TICKS, pt);
    write_reg(REG_POLL_LIMIT, 16'(pl));
  endtask

  task automatic random_burst(input int n_ticks);
    int         sent;
    int         extra;
    int         r;
    logic [2:0] cmd;
    sda_plan_e  plan;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(99) < 8) retune();
      r = $urandom_range(99);
      cmd = (r < 85) ? 3'($urandom_range(OP_START, OP_READ)) :
            (r < 92) ? CMD_NONE : 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      plan = sda_plan_e'($urandom_range(3));
      send_tick(cmd, 8'($urandom), 1'($urandom_range(1)), sda_for(plan));
      run_out(plan, 10, extra);
      sent += extra + 1;
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : sink
    res_t got;
    res_t want;
    int   stall_left;
    bit   hold_off_taken;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.scl_level = m_tdata[0];
        got.sda_level = m_tdata[1];
        got.sda_drive = m_tdata[2];
        got.busy_res  = m_tdata[3];
        got.done_res  = m_tdata[4];
        got.rx_byte   = m_tdata[12:5];
        got.nack      = m_tdata[13];
        if (due_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected output transfer, expected none, got %h", $time, m_tdata);
        end else begin
          want = due_outputs.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
          check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("nack", 8'(want.nack), 8'(got.nack));
        end
      end
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t steps[$];
    int        unused;
    // idle behaviour, reserved codes, START at the reset values, then the other commands over the register extremes
    steps.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, SDA_RAND, 1'b1, AT_REST));
    steps.push_back(tick_row(CMD_RSVD5, 8'hFF, 1'b1, 1'b1, 1'b0, SDA_RAND, 1'b1, AT_REST));
    steps.push_back(tick_row(CMD_RSVD6, 8'h00, 1'b0, 1'b1, 1'b0, SDA_RAND, 1'b1, AT_REST));
    steps.push_back(tick_row(CMD_RSVD7, 8'hFF, 1'b1, 1'b0, 1'b0, SDA_RAND, 1'b1, AT_REST));
    steps.push_back(tick_row(OP_START, 8'h00, 1'b0, 1'b1, 1'b1, SDA_RAND, 1'b1, START_ENTRY));
    steps.push_back(cfg_row(REG_PHASE_TICKS, 16'd0));
    steps.push_back(cfg_row(REG_POLL_LIMIT, 16'd0));
    steps.push_back(tick_row(OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1, SDA_HIGH, 1'b0, '0));
    steps.push_back(tick_row(OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, SDA_RAND, 1'b0, '0));
    steps.push_back(tick_row(OP_READ, 8'hFF, 1'b1, 1'b0, 1'b1, SDA_LOW, 1'b0, '0));
    steps.push_back(tick_row(OP_READ, 8'h00, 1'b0, 1'b1, 1'b1, SDA_HIGH, 1'b0, '0));
    steps.push_back(tick_row(OP_READ, 8'hFF, 1'b1, 1'b0, 1'b1, SDA_LOW, 1'b0, '0));
    steps.push_back(tick_row(OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1, SDA_RAND, 1'b0, '0));
    steps.push_back(cfg_row(REG_PHASE_TICKS, 16'd3));
    steps.push_back(cfg_row(REG_POLL_LIMIT, 16'd255));
    steps.push_back(tick_row(OP_WRITE, 8'hA5, 1'b1, 1'b1, 1'b1, SDA_MOSTLY_HIGH, 1'b0, '0));
    steps.push_back(tick_row(OP_READ, 8'h5A, 1'b1, 1'b0, 1'b1, SDA_RAND, 1'b0, '0));
    steps.push_back(tick_row(OP_STOP, 8'hC3, 1'b0, 1'b0, 1'b1, SDA_RAND, 1'b0, '0));
    steps.push_back(cfg_row(REG_POLL_LIMIT, 16'd2));
    steps.push_back(tick_row(OP_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1, SDA_HIGH, 1'b0, '0));
    steps.push_back(tick_row(OP_START, 8'h3C, 1'b1, 1'b0, 1'b1, SDA_RAND, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        write_reg(steps[i].cfg_idx, steps[i].cfg_val);
      end else begin
        send_tick(steps[i].cmd, steps[i].tx, steps[i].fin, steps[i].sda);
        if (steps[i].typed) begin
          void'(due_outputs.pop_back());
          due_outputs.push_back(steps[i].exp);
        end
        if (steps[i].go_on) run_out(steps[i].plan, 0, unused);
      end
    end

    write_reg(REG_PHASE_TICKS, 16'd1);
    write_reg(REG_POLL_LIMIT, 16'd1);
    random_burst(RANDOM_TICKS);

    src_idle_pct = 69;
    sink_idle_pct = 16;
    retune();
    random_burst(RANDOM_TICKS);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    retune();
    hold_off_req = 1'b1;
    random_burst(RANDOM_TICKS);

    // longest phase the counter holds; only the first ticks of it are run
    write_reg(REG_PHASE_TICKS, 16'hFFFF);
    write_reg(REG_POLL_LIMIT, 16'd255);
    send_tick(OP_START, 8'h00, 1'b0, 1'b1);
    repeat (8) send_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);

    s_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
